// ===== rtl/etare_pkg.sv =====
// Shared constants, types and the root table of the attack/release envelope generator.
// Depends on nothing; the RTL files refer to it by scoped names, the testbench files import it.
`timescale 1ns / 1ps
`default_nettype none
package etare_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int LENGTH_BITS   = 20;
    localparam int THR_BITS      = 16;
    localparam int CURVE_BITS    = 16;
    localparam int ENV_BITS      = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam int P_BITS        = $clog2(LENGTH_BITS);
    localparam int FRAC_BITS     = 16;
    localparam int LOG_BITS      = P_BITS + FRAC_BITS;
    localparam int T_BITS        = LOG_BITS + CURVE_BITS - 12;
    localparam int M_BITS        = 32;
    localparam int STEP_BITS     = 4;
    localparam int CMP_BITS      = SAMPLE_BITS + 34;

    localparam logic [ENV_BITS-1:0]    ONE_Q15         = ENV_BITS'(32768);
    localparam logic [THR_BITS-1:0]    RST_THRESHOLD   = THR_BITS'(16384);
    localparam logic [LENGTH_BITS-1:0] RST_ATTACK_LEN  = LENGTH_BITS'(1440);
    localparam logic [LENGTH_BITS-1:0] RST_RELEASE_LEN = LENGTH_BITS'(4800);
    localparam logic [CURVE_BITS-1:0]  RST_ATTACK_CRV  = CURVE_BITS'(8192);
    localparam logic [CURVE_BITS-1:0]  RST_RELEASE_CRV = CURVE_BITS'(2048);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_THRESHOLD     = 3'd0,
        REG_ATTACK_LEN    = 3'd1,
        REG_RELEASE_LEN   = 3'd2,
        REG_ATTACK_CURVE  = 3'd3,
        REG_RELEASE_CURVE = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD_DEN, S_LOG_DEN, S_LOAD_NUM, S_LOG_NUM,
        S_SCALE, S_EXP, S_FINISH, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_LOAD_DEN, OP_LOAD_NUM, OP_LOG_STEP,
        OP_SCALE, OP_EXP_STEP, OP_FINISH, OP_OUT
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [STEP_BITS-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic need_power;
        logic out_free;
    } t_status;

    // integer square root, elaboration only
    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-2^-k) in Q1.31, each one the truncated root of the one before
    function automatic logic [M_BITS-1:0] f_root(input int k);
        logic [63:0] s;
        s = 64'h4000_0000;
        for (int i = 1; i <= k; i++) begin
            s = f_isqrt(s << 31);
        end
        return s[M_BITS-1:0];
    endfunction

    localparam logic [M_BITS-1:0] C_ROOT [16] = '{
        f_root(1),  f_root(2),  f_root(3),  f_root(4),
        f_root(5),  f_root(6),  f_root(7),  f_root(8),
        f_root(9),  f_root(10), f_root(11), f_root(12),
        f_root(13), f_root(14), f_root(15), f_root(16)
    };

endpackage
`default_nettype wire

// ===== rtl/etare_sample_if.sv =====
// Input channel of the envelope generator: valid/ready and one sample per word.
// Depends on etare_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface etare_sample_if;
    logic                                         valid;
    logic                                         ready;
    logic signed [etare_pkg::SAMPLE_BITS-1:0]     sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== rtl/etare_env_if.sv =====
// Output channel of the envelope generator: valid/ready and one envelope level per word.
// Depends on etare_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface etare_env_if;
    logic                              valid;
    logic                              ready;
    logic [etare_pkg::ENV_BITS-1:0]    envelope;
    modport source (output valid, output envelope, input ready);
    modport sink   (input valid, input envelope, output ready);
endinterface
`default_nettype wire

// ===== rtl/etare_ctrl.sv =====
// Sequencer of the envelope generator: walks log, scale and exponent steps for each word on the curve.
// Depends on etare_pkg; drives the datapath by a command struct.
`timescale 1ns / 1ps
`default_nettype none
module etare_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire etare_pkg::t_status i_status,
    output etare_pkg::t_cmd         o_cmd
);

    etare_pkg::t_state                    r_state;
    etare_pkg::t_state                    n_state;
    logic [etare_pkg::STEP_BITS-1:0]      r_step;
    logic [etare_pkg::STEP_BITS-1:0]      n_step;
    logic                                 w_last;

    assign w_last = (r_step == {etare_pkg::STEP_BITS{1'b1}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etare_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        case (r_state)
            etare_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.need_power ? etare_pkg::S_LOAD_DEN : etare_pkg::S_DONE;
                end
            end
            etare_pkg::S_LOAD_DEN: n_state = etare_pkg::S_LOG_DEN;
            etare_pkg::S_LOG_DEN: begin
                n_step = r_step + 1'b1;
                if (w_last) n_state = etare_pkg::S_LOAD_NUM;
            end
            etare_pkg::S_LOAD_NUM: n_state = etare_pkg::S_LOG_NUM;
            etare_pkg::S_LOG_NUM: begin
                n_step = r_step + 1'b1;
                if (w_last) n_state = etare_pkg::S_SCALE;
            end
            etare_pkg::S_SCALE: n_state = etare_pkg::S_EXP;
            etare_pkg::S_EXP: begin
                n_step = r_step + 1'b1;
                if (w_last) n_state = etare_pkg::S_FINISH;
            end
            etare_pkg::S_FINISH: n_state = etare_pkg::S_DONE;
            etare_pkg::S_DONE: begin
                if (i_status.out_free) n_state = etare_pkg::S_IDLE;
            end
            default: n_state = etare_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = etare_pkg::OP_NONE;
        o_cmd.step = r_step;
        case (r_state)
            etare_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = etare_pkg::OP_ACCEPT;
            end
            etare_pkg::S_LOAD_DEN: o_cmd.op = etare_pkg::OP_LOAD_DEN;
            etare_pkg::S_LOG_DEN:  o_cmd.op = etare_pkg::OP_LOG_STEP;
            etare_pkg::S_LOAD_NUM: o_cmd.op = etare_pkg::OP_LOAD_NUM;
            etare_pkg::S_LOG_NUM:  o_cmd.op = etare_pkg::OP_LOG_STEP;
            etare_pkg::S_SCALE:    o_cmd.op = etare_pkg::OP_SCALE;
            etare_pkg::S_EXP:      o_cmd.op = etare_pkg::OP_EXP_STEP;
            etare_pkg::S_FINISH:   o_cmd.op = etare_pkg::OP_FINISH;
            etare_pkg::S_DONE: begin
                if (i_status.out_free) o_cmd.op = etare_pkg::OP_OUT;
            end
            default: o_cmd.op = etare_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/etare_datapath.sv =====
// Datapath of the envelope generator: registers, trigger logic, shared multiplier
// for log2 squaring, exponent scaling and root products, and the output register.
// Depends on etare_pkg.
`timescale 1ns / 1ps
`default_nettype none
module etare_datapath (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire etare_pkg::t_cmd                         i_cmd,
    output etare_pkg::t_status                           o_status,
    input  wire logic signed [etare_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                    i_cfg_we,
    input  wire logic [etare_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  wire logic [etare_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire logic                                    i_out_ready,
    output logic                                         o_out_valid,
    output logic [etare_pkg::ENV_BITS-1:0]               o_envelope
);

    localparam int SB = etare_pkg::SAMPLE_BITS;
    localparam int LB = etare_pkg::LENGTH_BITS;
    localparam int MB = etare_pkg::M_BITS;

    // configuration
    logic [etare_pkg::THR_BITS-1:0]   r_thr;
    logic [LB-1:0]                    r_alen;
    logic [LB-1:0]                    r_rlen;
    logic [etare_pkg::CURVE_BITS-1:0] r_acrv;
    logic [etare_pkg::CURVE_BITS-1:0] r_rcrv;

    // envelope state
    logic signed [SB-1:0] r_last;
    logic                 r_act;
    logic                 r_att;
    logic                 r_rel;
    logic [LB-1:0]        r_ac;
    logic [LB-1:0]        r_rc;

    // power unit
    logic [LB-1:0]                    r_num;
    logic [LB-1:0]                    r_den;
    logic [etare_pkg::CURVE_BITS-1:0] r_curve;
    logic [MB-1:0]                    r_m;
    logic [etare_pkg::P_BITS-1:0]     r_p;
    logic [etare_pkg::FRAC_BITS-1:0]  r_frac;
    logic [etare_pkg::LOG_BITS-1:0]   r_lden;
    logic [etare_pkg::T_BITS-1:0]     r_t;
    logic [etare_pkg::ENV_BITS-1:0]   r_res;
    logic                             r_out_valid;
    logic [etare_pkg::ENV_BITS-1:0]   r_out_env;

    // trigger decision
    logic signed [SB:0]                    w_diff;
    logic signed [etare_pkg::CMP_BITS-1:0] w_up;
    logic signed [etare_pkg::CMP_BITS-1:0] w_down;
    logic signed [etare_pkg::CMP_BITS-1:0] w_thr;
    logic                                  w_act;
    logic                                  w_att;
    logic                                  w_rel;
    logic [LB-1:0]                         w_ac;
    logic [LB-1:0]                         w_rc;
    logic [etare_pkg::ENV_BITS-1:0]        w_env;
    logic                                  w_pw;
    logic [LB-1:0]                         w_num;
    logic [LB-1:0]                         w_den;
    logic [etare_pkg::CURVE_BITS-1:0]      w_curve;

    logic [LB-1:0]                    w_v;
    logic [etare_pkg::P_BITS-1:0]     w_p;
    logic [MB-1:0]                    w_mnorm;
    logic [etare_pkg::LOG_BITS-1:0]   w_d;
    logic [MB-1:0]                    w_ma;
    logic [MB-1:0]                    w_mb;
    logic [2*MB-1:0]                  w_prod;
    logic [MB:0]                      w_sq;
    logic [15:0]                      w_tfrac;
    logic [etare_pkg::T_BITS-17:0]    w_ip;
    logic [MB-1:0]                    w_shift;
    logic [etare_pkg::ENV_BITS-1:0]   w_fin;

    assign w_diff = {i_sample[SB-1], i_sample} - {r_last[SB-1], r_last};
    assign w_up   = etare_pkg::CMP_BITS'(w_diff) <<< 15;
    assign w_down = -w_up;
    assign w_thr  = $signed(etare_pkg::CMP_BITS'(r_thr)) <<< (SB - 1);

    always_comb begin
        w_act   = r_act;
        w_att   = r_att;
        w_rel   = r_rel;
        w_ac    = r_ac;
        w_rc    = r_rc;
        w_env   = '0;
        w_pw    = 1'b0;
        w_num   = r_ac;
        w_den   = r_alen;
        w_curve = r_acrv;
        if (w_up > w_thr && !r_rel) begin
            w_act = 1'b1;
            w_att = 1'b1;
        end else if (w_down > w_thr && !r_att) begin
            w_act = 1'b0;
            w_rel = 1'b1;
        end
        if (w_act) begin
            // a shrunk or zero length ends the attack at once
            if (w_att && w_ac >= r_alen) begin
                w_att = 1'b0;
                w_ac  = '0;
            end
            if (w_att) begin
                w_pw    = 1'b1;
                w_num   = w_ac;
                w_den   = r_alen;
                w_curve = r_acrv;
                w_ac    = w_ac + 1'b1;
                if (w_ac >= r_alen) begin
                    w_ac  = '0;
                    w_att = 1'b0;
                end
            end else begin
                w_env = etare_pkg::ONE_Q15;
            end
        end
        if (w_rel) begin
            if (w_rc >= r_rlen) begin
                w_rel = 1'b0;
                w_rc  = '0;
            end else begin
                w_pw    = 1'b1;
                w_num   = r_rlen - w_rc;
                w_den   = r_rlen;
                w_curve = r_rcrv;
                w_rc    = w_rc + 1'b1;
                if (w_rc >= r_rlen) begin
                    w_rc  = '0;
                    w_rel = 1'b0;
                end
            end
        end
        // trivial powers
        if (w_pw) begin
            if (w_num >= w_den || w_curve == '0) begin
                w_pw  = 1'b0;
                w_env = etare_pkg::ONE_Q15;
            end else if (w_num == '0) begin
                w_pw  = 1'b0;
                w_env = '0;
            end
        end
    end

    // normalize the log2 operand to Q1.31
    assign w_v = (i_cmd.op == etare_pkg::OP_LOAD_DEN) ? r_den : r_num;

    always_comb begin
        w_p = '0;
        for (int i = 0; i < LB; i++) begin
            if (w_v[i]) w_p = etare_pkg::P_BITS'(i);
        end
    end

    assign w_mnorm = MB'(w_v) << (5'd31 - 5'(w_p));
    assign w_d     = r_lden - {r_p, r_frac};

    always_comb begin
        case (i_cmd.op)
            etare_pkg::OP_SCALE: begin
                w_ma = MB'(w_d);
                w_mb = MB'(r_curve);
            end
            etare_pkg::OP_EXP_STEP: begin
                w_ma = r_m;
                w_mb = etare_pkg::C_ROOT[i_cmd.step];
            end
            default: begin
                w_ma = r_m;
                w_mb = r_m;
            end
        endcase
    end

    assign w_prod  = w_ma * w_mb;
    assign w_sq    = w_prod[2*MB-1:MB-1];
    assign w_tfrac = r_t[15:0];
    assign w_ip    = r_t[etare_pkg::T_BITS-1:16];
    assign w_shift = (r_m >> 16) >> w_ip[3:0];

    always_comb begin
        if (w_ip > 15) begin
            w_fin = '0;
        end else if (w_shift > MB'(etare_pkg::ONE_Q15)) begin
            w_fin = etare_pkg::ONE_Q15;
        end else begin
            w_fin = w_shift[etare_pkg::ENV_BITS-1:0];
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= etare_pkg::RST_THRESHOLD;
            r_alen      <= etare_pkg::RST_ATTACK_LEN;
            r_rlen      <= etare_pkg::RST_RELEASE_LEN;
            r_acrv      <= etare_pkg::RST_ATTACK_CRV;
            r_rcrv      <= etare_pkg::RST_RELEASE_CRV;
            r_last      <= '0;
            r_act       <= 1'b0;
            r_att       <= 1'b0;
            r_rel       <= 1'b0;
            r_ac        <= '0;
            r_rc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (etare_pkg::t_reg_idx'(i_cfg_idx))
                    etare_pkg::REG_THRESHOLD:     r_thr  <= i_cfg_data[etare_pkg::THR_BITS-1:0];
                    etare_pkg::REG_ATTACK_LEN:    r_alen <= i_cfg_data[LB-1:0];
                    etare_pkg::REG_RELEASE_LEN:   r_rlen <= i_cfg_data[LB-1:0];
                    etare_pkg::REG_ATTACK_CURVE:  r_acrv <= i_cfg_data[etare_pkg::CURVE_BITS-1:0];
                    etare_pkg::REG_RELEASE_CURVE: r_rcrv <= i_cfg_data[etare_pkg::CURVE_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == etare_pkg::OP_ACCEPT) begin
                r_last <= i_sample;
                r_act  <= w_act;
                r_att  <= w_att;
                r_rel  <= w_rel;
                r_ac   <= w_ac;
                r_rc   <= w_rc;
            end
            if (i_cmd.op == etare_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            etare_pkg::OP_ACCEPT: begin
                r_num   <= w_num;
                r_den   <= w_den;
                r_curve <= w_curve;
                r_res   <= w_env;
            end
            etare_pkg::OP_LOAD_DEN: begin
                r_m    <= w_mnorm;
                r_p    <= w_p;
                r_frac <= '0;
            end
            etare_pkg::OP_LOAD_NUM: begin
                r_lden <= {r_p, r_frac};
                r_m    <= w_mnorm;
                r_p    <= w_p;
                r_frac <= '0;
            end
            etare_pkg::OP_LOG_STEP: begin
                r_m    <= w_sq[MB] ? w_sq[MB:1] : w_sq[MB-1:0];
                r_frac <= {r_frac[etare_pkg::FRAC_BITS-2:0], w_sq[MB]};
            end
            etare_pkg::OP_SCALE: begin
                r_t <= w_prod[etare_pkg::T_BITS+11:12];
                r_m <= {1'b1, {(MB-1){1'b0}}};
            end
            etare_pkg::OP_EXP_STEP: begin
                if (w_tfrac[4'hF - i_cmd.step]) r_m <= w_prod[2*MB-2:MB-1];
            end
            etare_pkg::OP_FINISH: r_res <= w_fin;
            etare_pkg::OP_OUT:    r_out_env <= r_res;
            default: ;
        endcase
    end

    assign o_status.need_power = w_pw;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_envelope          = r_out_env;

endmodule
`default_nettype wire

// ===== rtl/edge_triggered_ar_envelope_top.sv =====
// Channel   Dir  Word                 Handshake
// i_in      in   sample, Q1.15 signed valid/ready
// o_out     out  envelope, Q1.15      valid/ready
// i_cfg_*   in   register write       write enable only
//
// A word with a constant envelope (idle, hold, a finished phase) goes from accept
// straight to the output stage; a word on the curve passes two 16-step log2
// squarings, one scale multiply and 16 root products on one shared multiplier.
// Synchronous active-low reset; control state and configuration registers return to their defaults.
// The next word is taken once the previous one is in the output register; a
// stalled output blocks only the hand-over of the following result.
// Top level of the envelope generator; depends on etare_pkg, both channel
// interfaces, etare_ctrl and etare_datapath.
`timescale 1ns / 1ps
`default_nettype none
module edge_triggered_ar_envelope_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    etare_sample_if.sink                             i_in,
    etare_env_if.source                              o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [etare_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [etare_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    etare_pkg::t_cmd    w_cmd;
    etare_pkg::t_status w_status;

    etare_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    etare_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_sample    (i_in.sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_envelope  (o_out.envelope)
    );

`ifndef SYNTHESIS
    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.envelope <= etare_pkg::ONE_Q15)
        else $error("envelope above full scale");

    a_accept_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> w_cmd.op == etare_pkg::OP_ACCEPT)
        else $error("accepted word without accept command");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second word taken while one is in flight");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/etare_env_checker.sv =====
// Scoreboard for the envelope generator: predicts one envelope level per sample word
// and compares it with the output channel. Depends on etare_pkg and both channel interfaces.
`timescale 1ns / 1ps
module etare_env_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    etare_sample_if                                  i_in,
    etare_env_if                                     i_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [etare_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [etare_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                       o_fail_cnt,
    output int                                       o_pending
);
    import etare_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MASK = '1;

    logic [15:0]            thr_reg;
    logic [LENGTH_BITS-1:0] atk_len, rel_len;
    logic [15:0]            atk_crv, rel_crv;
    longint                 prev_sample;
    logic                   env_on, atk_run, rel_run;
    logic [LENGTH_BITS-1:0] atk_cnt, rel_cnt;
    logic [63:0]            root_q31 [17];
    logic [ENV_BITS-1:0]    level_q [$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v, r, b;
        v = v_in;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] log2_fix(input logic [63:0] v);
        int          p;
        logic [63:0] m, frac;
        p = 63;
        frac = 0;
        while (p > 0 && !v[p]) p--;
        m = (p > 31) ? (v >> (p - 31)) : (v << (31 - p));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(p) << 16) | frac;
    endfunction

    // (num/den)^(curve/4096) in Q1.15
    function automatic logic [ENV_BITS-1:0] curve_level(input logic [63:0] num,
                                                        input logic [63:0] den,
                                                        input logic [63:0] curve);
        logic [63:0] d, t, ip, f, m;
        if (num >= den || curve == 0) return ONE_Q15;
        if (num == 0) return '0;
        d = log2_fix(den) - log2_fix(num);
        t = (d * curve) >> 12;
        ip = t >> 16;
        f = t & 64'hFFFF;
        if (ip >= 16) return '0;
        m = 64'h8000_0000;
        for (int k = 1; k <= 16; k++)
            if (f[16-k]) m = (m * root_q31[k]) >> 31;
        m = m >> (16 + ip);
        return (m > 64'(ONE_Q15)) ? ONE_Q15 : m[ENV_BITS-1:0];
    endfunction

    task automatic advance_envelope(input logic signed [SAMPLE_BITS-1:0] smp);
        longint              nxt, diff;
        logic [ENV_BITS-1:0] lvl;
        nxt = longint'(smp);
        diff = nxt - prev_sample;
        lvl = '0;
        if (diff > longint'(thr_reg) && !rel_run) begin
            env_on = 1'b1;
            atk_run = 1'b1;
        end else if (-diff > longint'(thr_reg) && !atk_run) begin
            env_on = 1'b0;
            rel_run = 1'b1;
        end
        if (env_on) begin
            if (atk_run && atk_cnt >= atk_len) begin
                atk_run = 1'b0;
                atk_cnt = '0;
            end
            if (atk_run) begin
                lvl = curve_level(64'(atk_cnt), 64'(atk_len), 64'(atk_crv));
                atk_cnt = (atk_cnt + 1'b1) & LEN_MASK;
                if (atk_cnt >= atk_len) begin
                    atk_cnt = '0;
                    atk_run = 1'b0;
                end
            end else begin
                lvl = ONE_Q15;
            end
        end
        if (rel_run) begin
            if (rel_cnt >= rel_len) begin
                rel_run = 1'b0;
                rel_cnt = '0;
            end else begin
                lvl = curve_level(64'(rel_len - rel_cnt), 64'(rel_len), 64'(rel_crv));
                rel_cnt = (rel_cnt + 1'b1) & LEN_MASK;
                if (rel_cnt >= rel_len) begin
                    rel_cnt = '0;
                    rel_run = 1'b0;
                end
            end
        end
        prev_sample = nxt;
        level_q.push_back(lvl);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] envelope mismatch: %s", $time, msg);
        o_fail_cnt++;
    endtask

    initial begin
        o_fail_cnt = 0;
        root_q31[0] = 64'h4000_0000;
        for (int k = 1; k <= 16; k++) root_q31[k] = int_sqrt(root_q31[k-1] << 31);
    end

    assign o_pending = level_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_reg = RST_THRESHOLD;
            atk_len = RST_ATTACK_LEN;
            rel_len = RST_RELEASE_LEN;
            atk_crv = RST_ATTACK_CRV;
            rel_crv = RST_RELEASE_CRV;
            prev_sample = 0;
            env_on = 1'b0;
            atk_run = 1'b0;
            rel_run = 1'b0;
            atk_cnt = '0;
            rel_cnt = '0;
            level_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_THRESHOLD:     thr_reg = i_cfg_data[15:0];
                    REG_ATTACK_LEN:    atk_len = i_cfg_data[LENGTH_BITS-1:0];
                    REG_RELEASE_LEN:   rel_len = i_cfg_data[LENGTH_BITS-1:0];
                    REG_ATTACK_CURVE:  atk_crv = i_cfg_data[15:0];
                    REG_RELEASE_CURVE: rel_crv = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (level_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %0d", i_out.envelope));
                end else begin
                    if (i_out.envelope !== level_q[0])
                        report_mismatch($sformatf("got %0d, want %0d",
                                                  i_out.envelope, level_q[0]));
                    void'(level_q.pop_front());
                end
            end
            if (i_in.valid && i_in.ready) advance_envelope(i_in.sample);
        end
    end
endmodule

// ===== tb/sv/edge_triggered_ar_envelope_top_tb.sv =====
// Stimulus and verdict for the envelope generator: phases of register settings, sample
// words with random idling and one long output stall. Depends on etare_pkg, the channel
// interfaces, edge_triggered_ar_envelope_top and etare_env_checker.
`timescale 1ns / 1ps
module edge_triggered_ar_envelope_top_tb;
    import etare_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_WORDS = 70;
    localparam int DRAIN_CYCLES = 64;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    int                       fail_cnt, pending;
    bit                       quiet = 1'b0;
    bit                       long_hold = 1'b0;
    int                       cur_thr = 16384;
    int                       last_word = 0;

    etare_sample_if in_ch ();
    etare_env_if    out_ch ();

    edge_triggered_ar_envelope_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    etare_env_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
    end

    initial begin
        #5ms;
        $display("[edge_triggered_ar_envelope_top] ERROR");
        $finish;
    end

    // output side: random stall bursts, plus one long hold-off on request
    initial begin : receiver
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                out_ch.ready = 1'b0;
                repeat (500) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (hold > 0) begin
                out_ch.ready = 1'b0;
                hold--;
            end else begin
                out_ch.ready = 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 17);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = CFG_DATA_BITS'(val);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // caller is at a negedge; returns at the negedge after the posedge the word is taken
    task automatic send_word(input int val);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.sample = SAMPLE_BITS'(val);
        do @(posedge i_clk); while (!in_ch.ready);
        last_word = val;
        @(negedge i_clk);
    endtask

    function automatic int clamp_sample(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int next_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) return int'($urandom_range(0, 65535)) - 32768;
        if (sel < 6) return clamp_sample(last_word + cur_thr + int'($urandom_range(1, 2000)));
        if (sel < 9) return clamp_sample(last_word - cur_thr - int'($urandom_range(1, 2000)));
        return clamp_sample(last_word + int'($urandom_range(0, 64)) - 32);
    endfunction

    task automatic wait_idle();
        int guard;
        guard = 0;
        while (pending != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int unsigned rand_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
    endfunction

    initial begin : stimulus
        int unsigned thr, alen, rlen, acrv, rcrv;
        int          directed [20] = '{0, 32767, -32768, 32767, 32767, -32768, -32768, 0,
                                       20000, 0, -20000, 0, 16385, 0, -16385, 0, 16384, 0,
                                       -1, 32767};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        foreach (directed[i]) send_word(directed[i]);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            in_ch.valid = 1'b0;
            wait_idle();
            case (ph)
                0: begin thr = 0; alen = 0; rlen = 0; acrv = 0; rcrv = 0; end
                1: begin thr = 65535; alen = 20'hFFFFF; rlen = 20'hFFFFF;
                         acrv = 65535; rcrv = 65535; end
                2: begin thr = 1000; alen = 20'hFFFFF; rlen = 20'hFFFFF;
                         acrv = $urandom_range(0, 65535); rcrv = $urandom_range(0, 65535); end
                3: begin thr = 2000; alen = 1; rlen = 1; acrv = 65535; rcrv = 1; end
                default: begin
                    thr = $urandom_range(0, 20000);
                    alen = rand_len();
                    rlen = rand_len();
                    acrv = $urandom_range(0, 65535);
                    rcrv = $urandom_range(0, 65535);
                end
            endcase
            write_reg(REG_THRESHOLD, thr);
            write_reg(REG_ATTACK_LEN, alen);
            write_reg(REG_RELEASE_LEN, rlen);
            write_reg(REG_ATTACK_CURVE, acrv);
            write_reg(REG_RELEASE_CURVE, rcrv);
            write_reg(REG_UNUSED, $urandom);
            cur_thr = int'(thr > 30000 ? 30000 : thr);
            quiet = (ph == NUM_PHASES - 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == 5 && n == 10) long_hold = 1'b1;
                send_word(next_word());
            end
        end
        in_ch.valid = 1'b0;
        wait_idle();
        if (fail_cnt == 0 && pending == 0) begin
            $display("[edge_triggered_ar_envelope_top] OK");
        end else begin
            $display("[edge_triggered_ar_envelope_top] ERROR");
        end
        $finish;
    end
endmodule
